// File: sv/fdli_pkg.sv
// Shared types and constants for the fractional delay line interpolator.
// Used by fdli_ctrl, fdli_dp and the top level; depends on nothing.
`timescale 1ns / 1ps
package fdli_pkg;

  // Delay memory geometry (the length is a power of two so taps wrap by masking)
  localparam int ADDR_W       = 14;
  localparam int DELAY_LENGTH = 1 << ADDR_W;

  // Field widths
  localparam int SAMPLE_W = 24;
  localparam int DELAY_W  = 22;
  localparam int FRAC_W   = 8;
  localparam int IP_W     = DELAY_W - FRAC_W;
  localparam int RAMP_W   = 16;
  localparam int STEP_W   = DELAY_W + 1;
  localparam int PROD_W   = SAMPLE_W + FRAC_W + 2;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DELAY_W;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_DELAY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_SAMPLES = 1'b1;

  // Reset values
  localparam logic [DELAY_W-1:0] TARGET_RESET = DELAY_W'(1228800);
  localparam logic [RAMP_W-1:0]  RAMP_RESET   = RAMP_W'(441);

  // Glide step divider: one quotient bit per cycle
  localparam int DIV_ITERS = DELAY_W;
  localparam int DIV_CNT_W = $clog2(DIV_ITERS);

  // Commands from controller to datapath
  typedef struct packed {
    logic clr;       // clearing pass: write zero at the clear address
    logic accept;    // input request taken, run the target change check
    logic div_step;  // one divider iteration
    logic div_last;  // last divider iteration, store the step
    logic rd_b;      // read second tap, capture first tap
    logic mul;       // form the fraction product
    logic fin;       // load result, write sample, advance pointer and glide
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;  // clear address is at the last word
    logic tgt_chg;   // target differs from the last target seen
    logic ramp_zero; // glide length is zero
  } dp_stat_t;

endpackage

// File: sv/fdli_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module fdli_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/fdli_ctrl.sv
// Sequencer for the fractional delay line: clear pass, divide, tap reads,
// interpolation and result handoff. Depends on fdli_pkg.
`timescale 1ns / 1ps
module fdli_ctrl import fdli_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_RDA   = 3'd3;
  localparam logic [2:0] S_RDB   = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          cnt_d        = '0;
          if (stat_i.tgt_chg && !stat_i.ramp_zero) begin
            state_d = S_DIV;
          end else begin
            state_d = S_RDA;
          end
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_ITERS - 1)) begin
          cmd_o.div_last = 1'b1;
          state_d        = S_RDA;
        end else begin
          cnt_d = cnt_q + DIV_CNT_W'(1);
        end
      end
      S_RDA: begin
        state_d = S_RDB;
      end
      S_RDB: begin
        cmd_o.rd_b = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid holds until the result is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.fin) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: sv/fdli_dp.sv
// Datapath of the fractional delay line: config registers, delay memory,
// glide divider, tap addressing and interpolation. Depends on fdli_pkg, fdli_ram.
`timescale 1ns / 1ps
module fdli_dp import fdli_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [SAMPLE_W-1:0]   in_sample_i,
  output logic [SAMPLE_W-1:0]   out_sample_o,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o
);

  // Control-side registers
  logic [DELAY_W-1:0] target_q, target_d;
  logic [RAMP_W-1:0]  ramp_q, ramp_d;
  logic [DELAY_W-1:0] last_q, last_d;
  logic [DELAY_W-1:0] current_q, current_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [RAMP_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0]  wp_q, wp_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;

  // Payload registers
  logic [SAMPLE_W-1:0]      sample_q;
  logic [SAMPLE_W-1:0]      a_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [SAMPLE_W-1:0]      out_q;
  logic [DELAY_W-1:0]       dvd_q;
  logic [RAMP_W-1:0]        rem_q;
  logic                     neg_q;

  logic [DELAY_W:0]         diff;
  logic [DELAY_W-1:0]       mag;
  logic [RAMP_W:0]          trial;
  logic                     ge;
  logic [DELAY_W-1:0]       quo;
  logic [STEP_W-1:0]        glide_sum;
  logic [IP_W-1:0]          ip;
  logic [FRAC_W-1:0]        frac;
  logic [ADDR_W-1:0]        tap_a, tap_b, raddr, waddr;
  logic [SAMPLE_W-1:0]      rdata, wdata;
  logic                     we;
  logic signed [SAMPLE_W:0] tap_diff;
  logic signed [PROD_W-1:0] prod_sh;

  assign stat_o.clr_last  = (clr_q == {ADDR_W{1'b1}});
  assign stat_o.tgt_chg   = (target_q != last_q);
  assign stat_o.ramp_zero = (ramp_q == '0);

  // Signed distance to the new target, as sign and magnitude
  assign diff = {1'b0, target_q} - {1'b0, current_q};
  assign mag  = diff[DELAY_W] ? DELAY_W'(-diff) : diff[DELAY_W-1:0];

  // Restoring divider iteration; the countdown holds the divisor meanwhile
  assign trial = {rem_q, dvd_q[DELAY_W-1]};
  assign ge    = (trial >= {1'b0, count_q});
  assign quo   = {dvd_q[DELAY_W-2:0], ge};

  assign glide_sum = {1'b0, current_q} + step_q;

  // Tap addresses wrap by masking to the memory length
  assign ip    = current_q[DELAY_W-1:FRAC_W];
  assign frac  = current_q[FRAC_W-1:0];
  assign tap_a = wp_q - ADDR_W'(ip);
  assign tap_b = tap_a - ADDR_W'(1);
  assign raddr = cmd_i.rd_b ? tap_b : tap_a;

  // Interpolation: a + floor((b - a) * f / 256)
  assign tap_diff = $signed({rdata[SAMPLE_W-1], rdata}) - $signed({a_q[SAMPLE_W-1], a_q});
  assign prod_sh  = prod_q >>> FRAC_W;

  // Memory write: zero during the clear pass, else the new sample
  assign we    = cmd_i.clr || cmd_i.fin;
  assign waddr = cmd_i.clr ? clr_q : wp_q;
  assign wdata = cmd_i.clr ? '0 : sample_q;

  fdli_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DELAY_LENGTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Next-state logic for control-side registers
  always_comb begin
    target_d  = target_q;
    ramp_d    = ramp_q;
    last_d    = last_q;
    current_d = current_q;
    step_d    = step_q;
    count_d   = count_q;
    wp_d      = wp_q;
    clr_d     = clr_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TARGET_DELAY: target_d = cfg_data_i[DELAY_W-1:0];
        REG_RAMP_SAMPLES: ramp_d   = cfg_data_i[RAMP_W-1:0];
        default: ;
      endcase
    end

    if (cmd_i.clr) begin
      clr_d = clr_q + ADDR_W'(1);
    end

    // Target change check at the start of a sample
    if (cmd_i.accept && stat_o.tgt_chg) begin
      last_d = target_q;
      if (stat_o.ramp_zero) begin
        current_d = target_q;
        count_d   = '0;
        step_d    = '0;
      end else begin
        count_d = ramp_q;
      end
    end

    if (cmd_i.div_last) begin
      step_d = neg_q ? STEP_W'(-{1'b0, quo}) : {1'b0, quo};
    end

    // Pointer advance and glide advance after the write
    if (cmd_i.fin) begin
      wp_d = wp_q + ADDR_W'(1);
      if (count_q != '0) begin
        count_d = count_q - RAMP_W'(1);
        if (count_q == RAMP_W'(1)) begin
          current_d = last_q;
        end else begin
          current_d = glide_sum[DELAY_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= TARGET_RESET;
      ramp_q    <= RAMP_RESET;
      last_q    <= TARGET_RESET;
      current_q <= TARGET_RESET;
      step_q    <= '0;
      count_q   <= '0;
      wp_q      <= '0;
      clr_q     <= '0;
    end else begin
      target_q  <= target_d;
      ramp_q    <= ramp_d;
      last_q    <= last_d;
      current_q <= current_d;
      step_q    <= step_d;
      count_q   <= count_d;
      wp_q      <= wp_d;
      clr_q     <= clr_d;
    end
  end

  // Payload: sample, divider, taps, product, result
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= in_sample_i;
      dvd_q    <= mag;
      neg_q    <= diff[DELAY_W];
      rem_q    <= '0;
    end
    if (cmd_i.div_step) begin
      dvd_q <= quo;
      rem_q <= ge ? RAMP_W'(trial - {1'b0, count_q}) : trial[RAMP_W-1:0];
    end
    if (cmd_i.rd_b) begin
      a_q <= rdata;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(tap_diff * $signed({1'b0, frac}));
    end
    if (cmd_i.fin) begin
      out_q <= a_q + prod_sh[SAMPLE_W-1:0];
    end
  end

  assign out_sample_o = out_q;

endmodule

// File: sv/fractional_delay_line_interp.sv
// Fractional delay line with linear interpolation and a gliding delay. After
// reset the block clears its 16384-word delay memory, one word per cycle, and
// takes no sample until the clear pass ends (configuration writes are taken
// as usual). Each sample then steps through accept, two reads of the single
// memory read port, the interpolation multiply and the result handoff. The
// first sample after a target change with a nonzero glide length first runs
// the glide step divider, one quotient bit per step, before its tap reads.
// A finished result waits in the output register; the next sample is accepted
// meanwhile, and its handoff waits only if that result has not yet been taken.
// Depends on fdli_pkg, fdli_ctrl, fdli_dp, fdli_ram.
`timescale 1ns / 1ps
module fractional_delay_line_interp import fdli_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,  // [23:0] in_sample
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata   // [23:0] out_sample
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fdli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fdli_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_sample_i  (s_axis_tdata[SAMPLE_W-1:0]),
    .out_sample_o (m_axis_tdata[SAMPLE_W-1:0]),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

`ifndef NO_ASSERTIONS
  // A result is never loaded over one still waiting to be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten before handoff");

  // Once a request is taken the block is busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken while busy");

  // Controller phases are mutually exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr, cmd.accept, cmd.div_step, cmd.rd_b, cmd.mul, cmd.fin}))
    else $error("overlapping datapath commands");

  // A finished handoff always raises output valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin |=> m_axis_tvalid)
    else $error("result loaded without valid");
`endif

endmodule

// File: bench/tb_top.sv
// Self-checking bench for fractional_delay_line_interp: a directed table, then
// random phases with glide settings changed between them, checked against a
// local delay memory and glide model, or a row's exp. Depends on fdli_pkg, RTL.
`timescale 1ns / 1ps
module tb_top;
  import fdli_pkg::*;

  localparam int RANDOM_ITEMS = 600;
  localparam int LIMIT_CYCLES = 600000;
  localparam int LONG_HOLD    = 240;
  localparam int DRAIN_CYCLES = 80;
  localparam int N_DIR        = 35;

  typedef enum logic [1:0] {ROW_SMP, ROW_TARGET, ROW_RAMP} row_kind_e;
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_COMB, RX_SPARSE} rx_mode_e;

  // One row of the directed table; exp is only meaningful when has_exp is set
  typedef struct packed {
    row_kind_e            kind;
    logic [SAMPLE_W-1:0]  val;
    logic                 has_exp;
    logic [SAMPLE_W-1:0]  exp;
  } dir_row_t;

  // One sample request waiting for the input stream
  typedef struct packed {
    logic [SAMPLE_W-1:0] smp;
    logic                has_exp;
    logic [SAMPLE_W-1:0] exp;
  } smp_req_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_valid;
  logic                  s_ready;
  logic [23:0]           s_data;
  logic                  m_valid;
  logic                  m_ready;
  logic [23:0]           m_data;

  fractional_delay_line_interp DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  // Model state: delay memory, pointer, glide and register shadows
  logic signed [SAMPLE_W-1:0] dly_mem [DELAY_LENGTH];
  logic [ADDR_W-1:0]          wr_ptr;
  logic [DELAY_W-1:0]         cur_delay;
  logic [DELAY_W-1:0]         last_tgt;
  logic signed [STEP_W-1:0]   glide_step;
  logic [RAMP_W-1:0]          glide_left;
  logic [DELAY_W-1:0]         tgt_sh;
  logic [RAMP_W-1:0]          ramp_sh;

  smp_req_t            smp_q [$];
  logic [SAMPLE_W-1:0] out_exp_q [$];
  logic                pend;
  int                  err_cnt;
  int                  cycle_cnt;
  int                  hold_asked;
  int                  hold_served;

  dir_row_t dir_tbl [N_DIR];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance the model by one sample and return the interpolated output
  function automatic logic [SAMPLE_W-1:0] interp_next(input logic [SAMPLE_W-1:0] smp);
    logic [IP_W-1:0]   whole;
    logic [FRAC_W-1:0] frac;
    logic [ADDR_W-1:0] tap_a;
    logic [ADDR_W-1:0] tap_b;
    longint            tap_av;
    longint            tap_bv;
    longint            acc;
    int                diff;
    logic [SAMPLE_W-1:0] res;
    // new target: jump at once or start a glide
    if (tgt_sh != last_tgt) begin
      last_tgt = tgt_sh;
      if (ramp_sh == '0) begin
        cur_delay  = last_tgt;
        glide_left = '0;
        glide_step = '0;
      end else begin
        diff       = int'(last_tgt) - int'(cur_delay);
        glide_step = STEP_W'(diff / int'(ramp_sh));
        glide_left = ramp_sh;
      end
    end
    // two taps, read before the write
    whole  = cur_delay[DELAY_W-1:FRAC_W];
    frac   = cur_delay[FRAC_W-1:0];
    tap_a  = ADDR_W'(wr_ptr - whole);
    tap_b  = ADDR_W'(wr_ptr - whole - 1'b1);
    tap_av = longint'(dly_mem[tap_a]);
    tap_bv = longint'(dly_mem[tap_b]);
    acc    = tap_av * (longint'(256) - longint'(frac)) + tap_bv * longint'(frac);
    res    = SAMPLE_W'(acc >>> FRAC_W);
    dly_mem[wr_ptr] = smp;
    wr_ptr = wr_ptr + 1'b1;
    // glide advance; the last step lands exactly on the target
    if (glide_left != '0) begin
      glide_left = glide_left - 1'b1;
      if (glide_left == '0) cur_delay = last_tgt;
      else cur_delay = DELAY_W'(int'(cur_delay) + int'(glide_step));
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                 input logic [SAMPLE_W-1:0] want);
    $display("[%0t] MISMATCH %s: got %06h want %06h", $time, what, got, want);
    err_cnt++;
  endtask

  // Block is idle once no request is queued, in flight or owed a result
  task automatic settle();
    while (smp_q.size() != 0 || pend || out_exp_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    if (idx == REG_TARGET_DELAY) tgt_sh = val[DELAY_W-1:0];
    else if (idx == REG_RAMP_SAMPLES) ramp_sh = val[RAMP_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return SAMPLE_W'($urandom_range(0, 255));
      3: return ~SAMPLE_W'($urandom_range(0, 255));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Sender: bursts of requests separated by random gaps
  initial begin : sender
    int       burst_left;
    int       gap_left;
    smp_req_t cur;
    s_valid    = 1'b0;
    s_data     = '0;
    pend       = 1'b0;
    burst_left = 0;
    gap_left   = 0;
    cur        = '0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!pend) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (smp_q.size() != 0) begin
          cur  = smp_q.pop_front();
          pend = 1'b1;
          burst_left--;
        end
      end
      s_valid = pend;
      s_data  = pend ? cur.smp : SAMPLE_W'($urandom);
      @(posedge clk);
      if (s_valid && s_ready) begin
        pend = 1'b0;
        if (cur.has_exp) begin
          void'(interp_next(cur.smp));
          out_exp_q.push_back(cur.exp);
        end else begin
          out_exp_q.push_back(interp_next(cur.smp));
        end
      end
    end
  end

  // Receiver: stall patterns that change every so often, plus long hold-offs
  initial begin : receiver
    rx_mode_e mode;
    int       mode_left;
    int       hold_left;
    int       tick;
    m_ready     = 1'b0;
    hold_served = 0;
    mode        = RX_FREE;
    mode_left   = 0;
    hold_left   = 0;
    tick        = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        m_ready = 1'b0;
      end else if (hold_served != hold_asked) begin
        hold_served++;
        hold_left = LONG_HOLD;
        m_ready   = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          RX_FREE:   m_ready = 1'b1;
          RX_COIN:   m_ready = 1'($urandom_range(0, 1));
          RX_COMB:   m_ready = (tick % 5) > 1;
          default:   m_ready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    if (m_valid && m_ready) begin
      if (out_exp_q.size() == 0) report_mismatch("unexpected out_sample", m_data, '0);
      else begin
        if (m_data !== out_exp_q[0]) report_mismatch("out_sample", m_data, out_exp_q[0]);
        void'(out_exp_q.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : main
    int                  phase;
    int                  rnd_sent;
    int                  n;
    logic [DELAY_W-1:0]  tgt;
    logic [RAMP_W-1:0]   rmp;
    smp_req_t            req;
    cfg_we      = 1'b0;
    cfg_idx     = REG_TARGET_DELAY;
    cfg_data    = '0;
    err_cnt     = 0;
    hold_asked  = 0;
    for (int k = 0; k < DELAY_LENGTH; k++) dly_mem[k] = '0;
    wr_ptr     = '0;
    cur_delay  = TARGET_RESET;
    last_tgt   = TARGET_RESET;
    tgt_sh     = TARGET_RESET;
    ramp_sh    = RAMP_RESET;
    glide_step = '0;
    glide_left = '0;

    // Directed table: reset delay, one-sample and half-sample delays at full
    // scale, zero delay, longest delay wrapping, glides and a ramp length
    // rewritten mid-glide
    dir_tbl = '{
      '{ROW_SMP,    24'h7FFFFF, 1'b1, 24'h000000},
      '{ROW_SMP,    24'h800000, 1'b1, 24'h000000},
      '{ROW_RAMP,   24'h000000, 1'b0, 24'h000000},
      '{ROW_TARGET, 24'h000100, 1'b0, 24'h000000},
      '{ROW_SMP,    24'h123456, 1'b1, 24'h800000},
      '{ROW_SMP,    24'h000001, 1'b1, 24'h123456},
      '{ROW_SMP,    24'h7FFFFF, 1'b1, 24'h000001},
      '{ROW_SMP,    24'h800000, 1'b1, 24'h7FFFFF},
      '{ROW_TARGET, 24'h000180, 1'b0, 24'h000000},
      '{ROW_SMP,    24'h000002, 1'b1, 24'hFFFFFF},
      '{ROW_SMP,    24'h7FFFFF, 1'b0, 24'h000000},
      '{ROW_TARGET, 24'h000000, 1'b0, 24'h000000},
      '{ROW_SMP,    24'h5A5A5A, 1'b1, 24'h000000},
      '{ROW_TARGET, 24'h3FFFFF, 1'b0, 24'h000000},
      '{ROW_SMP,    24'hA5A5A5, 1'b1, 24'h000000},
      '{ROW_RAMP,   24'h000004, 1'b0, 24'h000000},
      '{ROW_TARGET, 24'h000400, 1'b0, 24'h000000},
      '{ROW_SMP,    24'h000100, 1'b0, 24'h000000},
      '{ROW_SMP,    24'h3FFFFF, 1'b0, 24'h000000},
      '{ROW_SMP,    24'hC00000, 1'b0, 24'h000000},
      '{ROW_SMP,    24'hFFFFFF, 1'b0, 24'h000000},
      '{ROW_RAMP,   24'h000008, 1'b0, 24'h000000},
      '{ROW_TARGET, 24'h000A00, 1'b0, 24'h000000},
      '{ROW_SMP,    24'h00FF00, 1'b0, 24'h000000},
      '{ROW_SMP,    24'h7F0F0F, 1'b0, 24'h000000},
      '{ROW_RAMP,   24'h00FFFF, 1'b0, 24'h000000},
      '{ROW_SMP,    24'h80F0F0, 1'b0, 24'h000000},
      '{ROW_SMP,    24'h000000, 1'b0, 24'h000000},
      '{ROW_TARGET, 24'h000A28, 1'b0, 24'h000000},
      '{ROW_SMP,    24'h111111, 1'b0, 24'h000000},
      '{ROW_SMP,    24'hEEEEEE, 1'b0, 24'h000000},
      '{ROW_RAMP,   24'h000001, 1'b0, 24'h000000},
      '{ROW_TARGET, 24'h02A5A5, 1'b0, 24'h000000},
      '{ROW_SMP,    24'h0F0F0F, 1'b0, 24'h000000},
      '{ROW_SMP,    24'hF0F0F0, 1'b0, 24'h000000}
    };

    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tbl[r]) begin
      case (dir_tbl[r].kind)
        ROW_TARGET: begin
          settle();
          write_reg(REG_TARGET_DELAY, dir_tbl[r].val[CFG_DATA_W-1:0]);
        end
        ROW_RAMP: begin
          settle();
          write_reg(REG_RAMP_SAMPLES, dir_tbl[r].val[CFG_DATA_W-1:0]);
        end
        default: smp_q.push_back(smp_req_t'{dir_tbl[r].val, dir_tbl[r].has_exp,
                                            dir_tbl[r].exp});
      endcase
    end

    // Random phases: new glide settings while idle, then a batch of samples
    phase    = 0;
    rnd_sent = 0;
    while (rnd_sent < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 9))
        0:       tgt = '0;
        1:       tgt = '1;
        2:       tgt = DELAY_W'($urandom);
        3:       tgt = tgt_sh;
        default: tgt = DELAY_W'($urandom_range(0, 80 * 256));
      endcase
      case ($urandom_range(0, 9))
        0:       rmp = '0;
        1:       rmp = '1;
        2:       rmp = RAMP_W'($urandom);
        3:       rmp = ramp_sh;
        default: rmp = RAMP_W'($urandom_range(1, 12));
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(REG_RAMP_SAMPLES, CFG_DATA_W'(rmp));
        if ($urandom_range(0, 4) != 0) write_reg(REG_TARGET_DELAY, tgt);
      end else begin
        write_reg(REG_TARGET_DELAY, tgt);
        if ($urandom_range(0, 2) == 0) write_reg(REG_RAMP_SAMPLES, CFG_DATA_W'(rmp));
      end
      // output held off while the sender keeps pushing
      if (phase % 6 == 2) hold_asked++;
      n = $urandom_range(8, 48);
      for (int k = 0; k < n; k++) begin
        req.smp     = rand_sample();
        req.has_exp = 1'b0;
        req.exp     = '0;
        smp_q.push_back(req);
      end
      rnd_sent += n;
      phase++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_cnt == 0 && out_exp_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// File: filelist.f
sv/fdli_pkg.sv
sv/fdli_ram.sv
sv/fdli_ctrl.sv
sv/fdli_dp.sv
sv/fractional_delay_line_interp.sv
bench/tb_top.sv
